[rtl/sdtq_pkg.sv]
// Shared types, constants and codes of the sorted deadline timer queue.
package sdtq_pkg;

   // Default number of timer entries held in the queue.
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Fixed field widths of the request and result payloads.
   localparam int HANDLE_BITS = 8;
   localparam int TIME_BITS   = 32;
   localparam int COUNT_BITS  = 5;

   // Request operations.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_TICK   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EXPIRED   = 3'd1,
      STAT_NONE      = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_DUPLICATE = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_EXECUTE = 2'd2,
      S_TICK    = 2'd3
   } state_type;

   // One request.
   typedef struct packed {
      op_type                 operation;
      logic [HANDLE_BITS-1:0] event_handle;
      logic [TIME_BITS-1:0]   deadline;
      logic                   immediate;
      logic [TIME_BITS-1:0]   now;
   } req_type;

   // One result.
   typedef struct packed {
      status_type             status;
      logic [HANDLE_BITS-1:0] expired_handle;
      logic                   fire_immediate;
      logic                   last_result;
      logic [COUNT_BITS-1:0]  active_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       compare;
      logic       insert;
      logic       remove;
      logic       pop;
      logic       emit;
      status_type status;
      logic       last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type operation;
      logic   duplicate;
      logic   full;
      logic   head_expired;
      logic   next_expired;
   } dp_status_type;

endpackage

[rtl/sdtq_ctrl.sv]
// Controller state machine of the sorted deadline timer queue.
module sdtq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sdtq_pkg::dp_status_type dp_status,
   output sdtq_pkg::cmd_type      cmd
);

   sdtq_pkg::state_type state_ff;
   sdtq_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdtq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdtq_pkg::S_IDLE: begin
            if (start) begin
               state_in = sdtq_pkg::S_COMPARE;
            end
         end
         sdtq_pkg::S_COMPARE: begin
            if (dp_status.operation == sdtq_pkg::OP_TICK) begin
               state_in = sdtq_pkg::S_TICK;
            end else begin
               state_in = sdtq_pkg::S_EXECUTE;
            end
         end
         sdtq_pkg::S_EXECUTE: begin
            state_in = sdtq_pkg::S_IDLE;
         end
         sdtq_pkg::S_TICK: begin
            // Stay while another expired entry follows the head.
            if (!(dp_status.head_expired && dp_status.next_expired)) begin
               state_in = sdtq_pkg::S_IDLE;
            end
         end
         default: state_in = sdtq_pkg::S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      cmd.status   = sdtq_pkg::STAT_OK;
      busy         = (state_ff != sdtq_pkg::S_IDLE);
      unique case (state_ff)
         sdtq_pkg::S_IDLE: begin
            cmd.load_req = start;
         end
         sdtq_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
         end
         sdtq_pkg::S_EXECUTE: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            priority case (dp_status.operation)
               sdtq_pkg::OP_INSERT: begin
                  if (dp_status.duplicate) begin
                     cmd.status = sdtq_pkg::STAT_DUPLICATE;
                  end else if (dp_status.full) begin
                     cmd.status = sdtq_pkg::STAT_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               sdtq_pkg::OP_DELETE: begin
                  if (dp_status.duplicate) begin
                     cmd.remove = 1'b1;
                  end else begin
                     cmd.status = sdtq_pkg::STAT_NOT_FOUND;
                  end
               end
               default: cmd.status = sdtq_pkg::STAT_OK;
            endcase
         end
         sdtq_pkg::S_TICK: begin
            cmd.emit = 1'b1;
            if (dp_status.head_expired) begin
               cmd.pop    = 1'b1;
               cmd.status = sdtq_pkg::STAT_EXPIRED;
               cmd.last   = !dp_status.next_expired;
            end else begin
               cmd.status = sdtq_pkg::STAT_NONE;
               cmd.last   = 1'b1;
            end
         end
         default: cmd.status = sdtq_pkg::STAT_OK;
      endcase
   end

endmodule

[rtl/sdtq_datapath.sv]
// Datapath of the sorted deadline timer queue: the shifting sorted entry chain.
module sdtq_datapath #(
   parameter int QUEUE_DEPTH = sdtq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdtq_pkg::req_type       req_payload,
   input  sdtq_pkg::cmd_type       cmd,
   output sdtq_pkg::dp_status_type dp_status,
   output logic                    rsp_strobe,
   output sdtq_pkg::rsp_type       rsp_payload
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Latched request.
   sdtq_pkg::req_type req_ff;

   // Entry chain, earliest deadline in cell zero.
   logic [sdtq_pkg::TIME_BITS-1:0]   deadline_ff [QUEUE_DEPTH];
   logic [sdtq_pkg::TIME_BITS-1:0]   deadline_in [QUEUE_DEPTH];
   logic [sdtq_pkg::HANDLE_BITS-1:0] handle_ff   [QUEUE_DEPTH];
   logic [sdtq_pkg::HANDLE_BITS-1:0] handle_in   [QUEUE_DEPTH];
   logic                             imm_ff      [QUEUE_DEPTH];
   logic                             imm_in      [QUEUE_DEPTH];
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;

   // Per-cell compare flags, registered between compare and execute.
   logic [QUEUE_DEPTH-1:0] gt_ff;
   logic [QUEUE_DEPTH-1:0] gt_in;
   logic [QUEUE_DEPTH-1:0] match_ff;
   logic [QUEUE_DEPTH-1:0] match_in;

   // Registered result.
   logic              rsp_strobe_ff;
   sdtq_pkg::rsp_type rsp_ff;
   sdtq_pkg::rsp_type rsp_in;

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
   end

   // Each cell compares its own deadline and handle with the request.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
      logic cell_valid;
      assign cell_valid  = (CW'(g) < count_ff);
      assign gt_in[g]    = cell_valid && (deadline_ff[g] > req_ff.deadline);
      assign match_in[g] = cell_valid && (handle_ff[g] == req_ff.event_handle);
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         gt_ff    <= gt_in;
         match_ff <= match_in;
      end
   end

   // Next contents of each cell: hold, take the new entry, or shift.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [sdtq_pkg::TIME_BITS-1:0]   up_deadline;
      logic [sdtq_pkg::HANDLE_BITS-1:0] up_handle;
      logic                             up_imm;
      logic [sdtq_pkg::TIME_BITS-1:0]   dn_deadline;
      logic [sdtq_pkg::HANDLE_BITS-1:0] dn_handle;
      logic                             dn_imm;
      logic                             from_prev;
      logic                             take_new;
      logic                             from_next;
      logic [QUEUE_DEPTH-1:0]           low_mask;

      // Neighbour towards the head.
      if (g > 0) begin : g_up
         assign up_deadline = deadline_ff[g-1];
         assign up_handle   = handle_ff[g-1];
         assign up_imm      = imm_ff[g-1];
         assign from_prev   = gt_ff[g-1];
      end else begin : g_up_none
         assign up_deadline = deadline_ff[g];
         assign up_handle   = handle_ff[g];
         assign up_imm      = imm_ff[g];
         assign from_prev   = 1'b0;
      end

      // Neighbour towards the tail.
      if (g < QUEUE_DEPTH - 1) begin : g_dn
         assign dn_deadline = deadline_ff[g+1];
         assign dn_handle   = handle_ff[g+1];
         assign dn_imm      = imm_ff[g+1];
      end else begin : g_dn_none
         assign dn_deadline = deadline_ff[g];
         assign dn_handle   = handle_ff[g];
         assign dn_imm      = imm_ff[g];
      end

      // A cell at or after the deleted handle takes its tail neighbour.
      assign low_mask  = {QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - g);
      assign from_next = |(match_ff & low_mask);
      assign take_new  = !from_prev && (gt_ff[g] || (count_ff == CW'(g)));

      always_comb begin
         priority if (cmd.insert && from_prev) begin
            deadline_in[g] = up_deadline;
            handle_in[g]   = up_handle;
            imm_in[g]      = up_imm;
         end else if (cmd.insert && take_new) begin
            deadline_in[g] = req_ff.deadline;
            handle_in[g]   = req_ff.event_handle;
            imm_in[g]      = req_ff.immediate;
         end else if (cmd.pop || (cmd.remove && from_next)) begin
            deadline_in[g] = dn_deadline;
            handle_in[g]   = dn_handle;
            imm_in[g]      = dn_imm;
         end else begin
            deadline_in[g] = deadline_ff[g];
            handle_in[g]   = handle_ff[g];
            imm_in[g]      = imm_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      handle_ff   <= handle_in;
      imm_ff      <= imm_in;
   end

   // Entry count.
   always_comb begin
      priority if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.remove || cmd.pop) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Status towards the controller.
   assign dp_status.operation    = req_ff.operation;
   assign dp_status.duplicate    = |match_ff;
   assign dp_status.full         = (count_ff == CW'(QUEUE_DEPTH));
   assign dp_status.head_expired = (count_ff != '0) && (deadline_ff[0] <= req_ff.now);
   assign dp_status.next_expired = (count_ff > CW'(1)) && (deadline_ff[1] <= req_ff.now);

   // Result register.
   always_comb begin
      rsp_in.status         = cmd.status;
      rsp_in.expired_handle = cmd.pop ? handle_ff[0] : '0;
      rsp_in.fire_immediate = cmd.pop ? imm_ff[0] : 1'b0;
      rsp_in.last_result    = cmd.last;
      rsp_in.active_count   = sdtq_pkg::COUNT_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/sorted_deadline_timer_queue.sv]
// Top level of the sorted deadline timer queue.
//
// Holds up to QUEUE_DEPTH timers in a register chain sorted by deadline, earliest first.
// A request is taken when start is high and busy is low. Insert, delete and the unused
// operation go through these steps in order: the request is latched, every cell compares
// its deadline and handle in parallel, and the chain shifts; the result follows on the next
// cycle with rsp_strobe high. A tick is latched and compared alike; then the chain pops one
// entry from its head each cycle while the head has expired (a tick with none expired gives
// one result). Each result is shown for exactly one cycle and cannot be held off, so the
// receiver must take it then. The request ends with the result that has last_result set.
module sorted_deadline_timer_queue #(
   parameter int QUEUE_DEPTH = sdtq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sdtq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output sdtq_pkg::rsp_type rsp_payload
);

   sdtq_pkg::cmd_type       cmd;
   sdtq_pkg::dp_status_type dp_status;

   // Controller.
   sdtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Entry chain and result register.
   sdtq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // An accepted request keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

   // No result directly follows the last result of a request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_result) |=> !rsp_strobe)
      else $error("result follows the last result of a request");

   // Only expired entries can be followed by further results of the same request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status != sdtq_pkg::STAT_EXPIRED))
         |-> rsp_payload.last_result)
      else $error("single result without last marker");

   // A full rejection reports a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status == sdtq_pkg::STAT_FULL))
         |-> (rsp_payload.active_count == sdtq_pkg::COUNT_BITS'(QUEUE_DEPTH)))
      else $error("full rejection with queue not full");

endmodule
